@@ design/interval_arithmetic_unit_assert.svh @@
// assertion macros used by the interval unit checker
// depends on nothing; each macro expects clk and arst_n in scope
`ifndef INTERVAL_ARITHMETIC_UNIT_ASSERT_SVH
`define INTERVAL_ARITHMETIC_UNIT_ASSERT_SVH

// property that holds in the next cycle
`define IAU_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

// property that holds in the same cycle
`define IAU_ASSERT_NOW(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

`endif

@@ design/iau_pkg.sv @@
// shared types, opcodes and constants for the interval arithmetic unit
// depends on nothing
package iau_pkg;

	localparam int FRAC_BITS_DEF = 16;
	// quotient bits resolved per divider stage
	localparam int DIV_STEPS = 4;

	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;
	localparam logic [2:0] OP_ISECT = 3'd4;
	localparam logic [2:0] OP_HULL = 3'd5;
	localparam logic [2:0] OP_NEG = 3'd6;

	localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

	// request fields carried alongside the arithmetic
	typedef struct packed {
		logic [2:0] op;
		logic signed [31:0] a_lo;
		logic signed [31:0] a_hi;
		logic signed [31:0] b_lo;
		logic signed [31:0] b_hi;
		logic [31:0] d_lo;
		logic [31:0] d_hi;
		logic whole;
		logic rsat;
	} side_t;

	// saturate a 33-bit sum; msb of the result is the clip flag
	function automatic logic [32:0] sat33(input logic [32:0] v);
		logic [32:0] r;
		if (v[32] != v[31]) begin
			r = v[32] ? {1'b1, Q_MIN} : {1'b1, Q_MAX};
		end else begin
			r = {1'b0, v[31:0]};
		end
		return r;
	endfunction

endpackage

@@ design/iau_div_stage.sv @@
// one registered stage of the restoring divider for 2^(2*FRAC_BITS) / d
// depends on iau_pkg
module iau_div_stage import iau_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int QP = 36,
	parameter int IDX_HI = 35
) (
	input logic clk,
	input logic en,
	input logic [31:0] d,
	input logic [31:0] rem_in,
	input logic [QP-1:0] q_in,
	output logic [31:0] rem_out,
	output logic [QP-1:0] q_out
);

	logic [31:0] rem_w;
	logic [QP-1:0] q_w;

	// shift in one numerator bit per step, subtract when it fits
	always_comb begin
		logic [32:0] r33;
		logic nb;
		rem_w = rem_in;
		q_w = q_in;
		for (int k = 0; k < DIV_STEPS; k++) begin
			nb = ((IDX_HI - k) == 2 * FRAC_BITS);
			r33 = {rem_w, nb};
			if (r33 >= {1'b0, d}) begin
				r33 = r33 - {1'b0, d};
				q_w = {q_w[QP-2:0], 1'b1};
			end else begin
				q_w = {q_w[QP-2:0], 1'b0};
			end
			rem_w = r33[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_out <= rem_w;
			q_out <= q_w;
		end
	end

endmodule

@@ design/iau_imul.sv @@
// four-stage interval multiplier: products, pairwise min/max, final min/max, round and clip
// depends on iau_pkg
module iau_imul import iau_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input logic clk,
	input logic en,
	input logic signed [31:0] x_lo,
	input logic signed [31:0] x_hi,
	input logic signed [31:0] y_lo,
	input logic signed [31:0] y_hi,
	output logic signed [31:0] lo,
	output logic signed [31:0] hi,
	output logic sat
);

	localparam logic signed [64:0] MASK = {{(65 - FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};
	localparam logic signed [64:0] MAX65 = 65'(Q_MAX);
	localparam logic signed [64:0] MIN65 = 65'(Q_MIN);

	logic signed [63:0] p_s1 [4];
	logic signed [63:0] mn_s2 [2];
	logic signed [63:0] mx_s2 [2];
	logic signed [63:0] mn_s3;
	logic signed [63:0] mx_s3;
	logic signed [64:0] lo_w;
	logic signed [64:0] hi_w;

	// endpoint products
	always_ff @(posedge clk) begin
		if (en) begin
			p_s1[0] <= 64'(x_lo) * 64'(y_lo);
			p_s1[1] <= 64'(x_lo) * 64'(y_hi);
			p_s1[2] <= 64'(x_hi) * 64'(y_lo);
			p_s1[3] <= 64'(x_hi) * 64'(y_hi);
		end
	end

	// pairwise then final min/max
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 2; i++) begin
				mn_s2[i] <= (p_s1[2*i+1] < p_s1[2*i]) ? p_s1[2*i+1] : p_s1[2*i];
				mx_s2[i] <= (p_s1[2*i+1] > p_s1[2*i]) ? p_s1[2*i+1] : p_s1[2*i];
			end
			mn_s3 <= (mn_s2[1] < mn_s2[0]) ? mn_s2[1] : mn_s2[0];
			mx_s3 <= (mx_s2[1] > mx_s2[0]) ? mx_s2[1] : mx_s2[0];
		end
	end

	// floor the low bound, ceil the high bound
	assign lo_w = 65'(mn_s3) >>> FRAC_BITS;
	assign hi_w = (65'(mx_s3) + MASK) >>> FRAC_BITS;

	always_ff @(posedge clk) begin
		if (en) begin
			lo <= (lo_w > MAX65) ? Q_MAX : (lo_w < MIN65) ? Q_MIN : lo_w[31:0];
			hi <= (hi_w > MAX65) ? Q_MAX : (hi_w < MIN65) ? Q_MIN : hi_w[31:0];
			sat <= (lo_w > MAX65) || (lo_w < MIN65) || (hi_w > MAX65) || (hi_w < MIN65);
		end
	end

endmodule

@@ design/interval_arithmetic_unit.sv @@
// Interval arithmetic unit, signed fixed point bounds with FRAC_BITS fraction bits.
// Request channel: req_valid/req_ready with req_type and the bounds of A and B.
// Response channel: rsp_valid/rsp_ready with r_low, r_high and three flags.
// Opcodes: add, sub, mul, div, intersect, hull, negate A; code 7 returns zeros.
// One request may enter every cycle unless a held response stalls the pipeline.
// Each request passes through an input register, the reciprocal divider, which
// resolves four quotient bits per stage, one reciprocal hull stage, a four-stage
// interval multiplier and the response register.
// All operations use the same path, so responses leave in request order.
// Reset clears all valid bits; nothing else holds state between requests.
// When rsp_ready is low with a response waiting, the whole pipeline holds and
// req_ready drops in the same cycle; no request is lost or repeated.
// depends on iau_pkg, iau_div_stage, iau_imul
module interval_arithmetic_unit import iau_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	input logic [2:0] req_type,
	input logic signed [31:0] a_low,
	input logic signed [31:0] a_high,
	input logic signed [31:0] b_low,
	input logic signed [31:0] b_high,
	output logic rsp_valid,
	input logic rsp_ready,
	output logic signed [31:0] r_low,
	output logic signed [31:0] r_high,
	output logic empty_flag,
	output logic whole_flag,
	output logic saturated
);

	localparam int QW = 2 * FRAC_BITS + 1;
	localparam int ND = (QW + DIV_STEPS - 1) / DIV_STEPS;
	localparam int QP = ND * DIV_STEPS;
	localparam int RW = QP + 2;
	localparam int NS = ND + 6;
	localparam logic signed [RW-1:0] MAXR = RW'(Q_MAX);
	localparam logic signed [RW-1:0] MINR = RW'(Q_MIN);

	logic en;
	logic [NS-1:0] vld_s;
	side_t side_s [NS];
	side_t side_in;
	side_t side_rc;

	logic [31:0] rem_lo_s [ND+1];
	logic [31:0] rem_hi_s [ND+1];
	logic [QP-1:0] q_lo_s [ND+1];
	logic [QP-1:0] q_hi_s [ND+1];

	logic signed [31:0] y_lo_s;
	logic signed [31:0] y_hi_s;
	logic signed [31:0] m_lo;
	logic signed [31:0] m_hi;
	logic m_sat;

	// whole pipeline advances unless a response is held
	assign en = !rsp_valid || rsp_ready;
	assign req_ready = en;

	// input stage fields, divisor magnitudes and zero check
	always_comb begin
		side_in.op = req_type;
		side_in.a_lo = a_low;
		side_in.a_hi = a_high;
		side_in.b_lo = b_low;
		side_in.b_hi = b_high;
		side_in.d_lo = b_low[31] ? 32'(-b_low) : b_low;
		side_in.d_hi = b_high[31] ? 32'(-b_high) : b_high;
		side_in.whole = (b_low <= 0 && b_high >= 0) || b_low == 0 || b_high == 0;
		side_in.rsat = 1'b0;
	end

	// reciprocal hull from the divider results
	always_comb begin
		logic signed [RW-1:0] qa;
		logic signed [RW-1:0] ua;
		logic signed [RW-1:0] qb;
		logic signed [RW-1:0] ub;
		logic signed [RW-1:0] fl_a;
		logic signed [RW-1:0] ce_a;
		logic signed [RW-1:0] fl_b;
		logic signed [RW-1:0] ce_b;
		logic signed [RW-1:0] rlo;
		logic signed [RW-1:0] rhi;
		qa = RW'(q_lo_s[ND]);
		ua = qa + RW'(rem_lo_s[ND] != 32'd0);
		qb = RW'(q_hi_s[ND]);
		ub = qb + RW'(rem_hi_s[ND] != 32'd0);
		fl_a = side_s[ND].b_lo[31] ? -ua : qa;
		ce_a = side_s[ND].b_lo[31] ? -qa : ua;
		fl_b = side_s[ND].b_hi[31] ? -ub : qb;
		ce_b = side_s[ND].b_hi[31] ? -qb : ub;
		rlo = (fl_b < fl_a) ? fl_b : fl_a;
		rhi = (ce_b > ce_a) ? ce_b : ce_a;
		side_rc = side_s[ND];
		side_rc.rsat = (side_s[ND].op == OP_DIV) && !side_s[ND].whole &&
			(rlo > MAXR || rlo < MINR || rhi > MAXR || rhi < MINR);
		if (side_s[ND].op == OP_DIV) begin
			side_rc.b_lo = (rlo > MAXR) ? Q_MAX : (rlo < MINR) ? Q_MIN : rlo[31:0];
			side_rc.b_hi = (rhi > MAXR) ? Q_MAX : (rhi < MINR) ? Q_MIN : rhi[31:0];
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NS-2:0], req_valid};
		end
	end

	// carried request fields
	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= side_in;
			for (int i = 1; i < NS; i++) begin
				if (i == ND + 1) begin
					side_s[i] <= side_rc;
				end else begin
					side_s[i] <= side_s[i-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y_lo_s <= side_rc.b_lo;
			y_hi_s <= side_rc.b_hi;
		end
	end

	// divider chain, two divisors in parallel
	assign rem_lo_s[0] = '0;
	assign rem_hi_s[0] = '0;
	assign q_lo_s[0] = '0;
	assign q_hi_s[0] = '0;

	for (genvar j = 0; j < ND; j++) begin : g_div
		iau_div_stage #(
			.FRAC_BITS(FRAC_BITS),
			.QP(QP),
			.IDX_HI(QP - 1 - j * DIV_STEPS)
		) u_lo (
			.clk(clk),
			.en(en),
			.d(side_s[j].d_lo),
			.rem_in(rem_lo_s[j]),
			.q_in(q_lo_s[j]),
			.rem_out(rem_lo_s[j+1]),
			.q_out(q_lo_s[j+1])
		);
		iau_div_stage #(
			.FRAC_BITS(FRAC_BITS),
			.QP(QP),
			.IDX_HI(QP - 1 - j * DIV_STEPS)
		) u_hi (
			.clk(clk),
			.en(en),
			.d(side_s[j].d_hi),
			.rem_in(rem_hi_s[j]),
			.q_in(q_hi_s[j]),
			.rem_out(rem_hi_s[j+1]),
			.q_out(q_hi_s[j+1])
		);
	end

	// interval multiply for mul and div
	iau_imul #(.FRAC_BITS(FRAC_BITS)) u_imul (
		.clk(clk),
		.en(en),
		.x_lo(side_s[ND+1].a_lo),
		.x_hi(side_s[ND+1].a_hi),
		.y_lo(y_lo_s),
		.y_hi(y_hi_s),
		.lo(m_lo),
		.hi(m_hi),
		.sat(m_sat)
	);

	// result select and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (en) begin
			rsp_valid <= vld_s[NS-1];
		end
	end

	always_ff @(posedge clk) begin
		side_t s;
		logic [32:0] x0;
		logic [32:0] x1;
		s = side_s[NS-1];
		if (en) begin
			r_low <= '0;
			r_high <= '0;
			empty_flag <= 1'b0;
			whole_flag <= 1'b0;
			saturated <= 1'b0;
			unique case (s.op)
				OP_ADD: begin
					x0 = sat33(33'(s.a_lo) + 33'(s.b_lo));
					x1 = sat33(33'(s.a_hi) + 33'(s.b_hi));
					r_low <= x0[31:0];
					r_high <= x1[31:0];
					saturated <= x0[32] | x1[32];
				end
				OP_SUB: begin
					x0 = sat33(33'(s.a_lo) - 33'(s.b_hi));
					x1 = sat33(33'(s.a_hi) - 33'(s.b_lo));
					r_low <= x0[31:0];
					r_high <= x1[31:0];
					saturated <= x0[32] | x1[32];
				end
				OP_MUL: begin
					r_low <= m_lo;
					r_high <= m_hi;
					saturated <= m_sat;
				end
				OP_DIV: begin
					if (s.whole) begin
						r_low <= Q_MIN;
						r_high <= Q_MAX;
						whole_flag <= 1'b1;
					end else begin
						r_low <= m_lo;
						r_high <= m_hi;
						saturated <= m_sat | s.rsat;
					end
				end
				OP_ISECT: begin
					if (s.a_hi < s.b_lo || s.a_lo > s.b_hi) begin
						empty_flag <= 1'b1;
					end else begin
						r_low <= (s.a_lo > s.b_lo) ? s.a_lo : s.b_lo;
						r_high <= (s.a_hi < s.b_hi) ? s.a_hi : s.b_hi;
					end
				end
				OP_HULL: begin
					r_low <= (s.a_lo < s.b_lo) ? s.a_lo : s.b_lo;
					r_high <= (s.a_hi > s.b_hi) ? s.a_hi : s.b_hi;
				end
				OP_NEG: begin
					x0 = sat33(33'd0 - 33'(s.a_hi));
					x1 = sat33(33'd0 - 33'(s.a_lo));
					r_low <= x0[31:0];
					r_high <= x1[31:0];
					saturated <= x0[32] | x1[32];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

@@ design/iau_checker.sv @@
// port-level checks for the interval arithmetic unit, bound to the top level
// depends on iau_pkg and interval_arithmetic_unit_assert.svh
`include "interval_arithmetic_unit_assert.svh"

module iau_checker import iau_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic signed [31:0] r_low,
	input logic signed [31:0] r_high,
	input logic empty_flag,
	input logic whole_flag,
	input logic saturated
);

	// a held response keeps its bounds and saturated flag
	`IAU_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(r_low) && $stable(r_high) && $stable(saturated), "response changed while stalled")

	// a stalled response blocks new requests
	`IAU_ASSERT_NOW(a_stall_ready, rsp_valid && !rsp_ready, !req_ready, "request taken during stall")

	// whole range result is exact and unclipped
	`IAU_ASSERT_NOW(a_whole, rsp_valid && whole_flag, r_low == Q_MIN && r_high == Q_MAX && !saturated && !empty_flag, "bad whole range result")

	// empty intersect returns zero bounds
	`IAU_ASSERT_NOW(a_empty, rsp_valid && empty_flag, r_low == 0 && r_high == 0 && !saturated, "bad empty result")

endmodule

bind interval_arithmetic_unit iau_checker u_iau_checker (.*);
